>>> design/rhc_pkg.sv
// rhc_pkg: shared types, constants and helper functions for the rgb/hsv converter
// no dependencies

package rhc_pkg;

	localparam int FRAC_BITS = 12;
	localparam int CH_W      = 12;
	localparam int DIV_STEPS = CH_W;
	localparam int DIV_W     = 16;
	localparam int DIV_D_W   = 15;
	localparam logic [CH_W-1:0] SCALE = {CH_W{1'b1}};

	typedef enum logic {
		OP_RGB2HSV = 1'b0,
		OP_HSV2RGB = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5,
		SEC_6 = 3'd6
	} sector_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic             qbit;
	} div_step_t;

	// one restoring division step: shift in a numerator bit, subtract if it fits
	function automatic div_step_t div_step(input logic [DIV_W-1:0] rem,
			input logic nbit, input logic [DIV_D_W-1:0] d);
		logic [DIV_W-1:0] sh;
		logic [DIV_W-1:0] dx;
		div_step_t        res;
		sh = {rem[DIV_W-2:0], nbit};
		dx = {1'b0, d};
		if (sh >= dx) begin
			res.rem  = sh - dx;
			res.qbit = 1'b1;
		end else begin
			res.rem  = sh;
			res.qbit = 1'b0;
		end
		return res;
	endfunction

	// floor(x / 4095) for x up to 4095*4095, by fold and correction
	function automatic logic [CH_W-1:0] div_scale(input logic [2*CH_W-1:0] x);
		logic [CH_W-1:0] q0;
		logic [CH_W:0]   r0;
		logic [CH_W:0]   q;
		q0 = x[2*CH_W-1:CH_W];
		r0 = {1'b0, x[CH_W-1:0]} + {1'b0, q0};
		if (r0 >= {SCALE, 1'b0})
			q = {1'b0, q0} + 13'd2;
		else if (r0 >= {1'b0, SCALE})
			q = {1'b0, q0} + 13'd1;
		else
			q = {1'b0, q0};
		return q[CH_W-1:0];
	endfunction

	// start of each hue sector on the scale of hue * 6
	function automatic logic [CH_W+2:0] sector_base(input sector_t s);
		logic [CH_W+2:0] b;
		case (s)
			SEC_0:   b = 15'd0;
			SEC_1:   b = 15'd4095;
			SEC_2:   b = 15'd8190;
			SEC_3:   b = 15'd12285;
			SEC_4:   b = 15'd16380;
			SEC_5:   b = 15'd20475;
			SEC_6:   b = 15'd24570;
			default: b = 15'd0;
		endcase
		return b;
	endfunction

endpackage

>>> design/rgb_hsv_converter.sv
// rgb_hsv_converter: pipelined rgb <-> hsv converter, top level
// depends on rhc_pkg (types, division step, divide by scale)

// One request per clock: busy stays low and a request is taken at every
// clock edge where start is high. The result appears at the output register
// on res_first/res_second/res_third together with a one-cycle done strobe,
// and cannot be held off by the receiver. The pipeline depth is set by the two
// radix-2 restoring dividers (hue and saturation), one quotient bit per
// stage over twelve stages; the hsv-to-rgb path finishes early and rides
// along in a delay line so both ops leave in request order.
module rgb_hsv_converter
	import rhc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic            op,
	input  logic [CH_W-1:0] chan_first,
	input  logic [CH_W-1:0] chan_second,
	input  logic [CH_W-1:0] chan_third,
	output logic            done,
	output logic [CH_W-1:0] res_first,
	output logic [CH_W-1:0] res_second,
	output logic [CH_W-1:0] res_third
);

	// no back pressure, the pipe always takes a request
	assign busy = 1'b0;

	// ---- stage 1: input register
	logic            vld_s1;
	op_t             op_s1;
	logic [CH_W-1:0] c1_s1, c2_s1, c3_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		op_s1 <= op_t'(op);
		c1_s1 <= chan_first;
		c2_s1 <= chan_second;
		c3_s1 <= chan_third;
	end

	// ---- stage 2: max/min and range for rgb, hue*6 and v*s for hsv
	logic            rmax_c, gmax_c;
	logic [CH_W-1:0] mx_c, mn_c;

	always_comb begin
		mx_c = c1_s1;
		mn_c = c1_s1;
		if (c2_s1 > mx_c) mx_c = c2_s1;
		if (c3_s1 > mx_c) mx_c = c3_s1;
		if (c2_s1 < mn_c) mn_c = c2_s1;
		if (c3_s1 < mn_c) mn_c = c3_s1;
		// red wins ties, then green
		rmax_c = (c1_s1 == mx_c);
		gmax_c = (c2_s1 == mx_c);
	end

	logic              vld_s2;
	op_t               op_s2;
	logic [CH_W-1:0]   c1_s2, c2_s2, c3_s2, mx_s2, rng_s2;
	logic              rmax_s2, gmax_s2;
	logic [CH_W+2:0]   t_s2;
	logic [2*CH_W-1:0] vsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		op_s2   <= op_s1;
		c1_s2   <= c1_s1;
		c2_s2   <= c2_s1;
		c3_s2   <= c3_s1;
		mx_s2   <= mx_c;
		rng_s2  <= mx_c - mn_c;
		rmax_s2 <= rmax_c;
		gmax_s2 <= gmax_c;
		t_s2    <= ({3'b0, c1_s1} << 2) + ({3'b0, c1_s1} << 1);
		vsp_s2  <= {{CH_W{1'b0}}, c2_s1} * {{CH_W{1'b0}}, c3_s1};
	end

	// ---- stage 3: hue numerator, divider setup; hsv sector, frac, v*s/scale
	logic signed [16:0] r_x, g_x, b_x, rng_x, num_raw, num_w;
	logic [DIV_D_W-1:0] num_u, rng6;
	logic [26:0]        hnum;
	logic [2*CH_W-1:0]  snum;
	sector_t            sec_c;
	logic [CH_W+2:0]    frac_w;

	always_comb begin
		r_x   = $signed({5'b0, c1_s2});
		g_x   = $signed({5'b0, c2_s2});
		b_x   = $signed({5'b0, c3_s2});
		rng_x = $signed({5'b0, rng_s2});
		if (rmax_s2)
			num_raw = g_x - b_x;
		else if (gmax_s2)
			num_raw = (rng_x <<< 1) + b_x - r_x;
		else
			num_raw = (rng_x <<< 2) + r_x - g_x;
		// wrap negative hue into one full turn
		if (num_raw < 0)
			num_w = num_raw + (rng_x <<< 2) + (rng_x <<< 1);
		else
			num_w = num_raw;
		num_u = num_w[DIV_D_W-1:0];
		rng6  = ({3'b0, rng_s2} << 2) + ({3'b0, rng_s2} << 1);
		// times 4095 as shift and subtract
		hnum  = {num_u, 12'b0} - {12'b0, num_u};
		snum  = {rng_s2, 12'b0} - {12'b0, rng_s2};

		if (t_s2 >= sector_base(SEC_6))      sec_c = SEC_6;
		else if (t_s2 >= sector_base(SEC_5)) sec_c = SEC_5;
		else if (t_s2 >= sector_base(SEC_4)) sec_c = SEC_4;
		else if (t_s2 >= sector_base(SEC_3)) sec_c = SEC_3;
		else if (t_s2 >= sector_base(SEC_2)) sec_c = SEC_2;
		else if (t_s2 >= sector_base(SEC_1)) sec_c = SEC_1;
		else                                 sec_c = SEC_0;
		frac_w = t_s2 - sector_base(sec_c);
	end

	// divider pipe, index 0 is stage 3, index DIV_STEPS is stage 15
	logic               vld_d  [0:DIV_STEPS];
	op_t                op_d   [0:DIV_STEPS];
	logic               zero_d [0:DIV_STEPS];
	logic [DIV_W-1:0]   hrem_d [0:DIV_STEPS];
	logic [DIV_W-1:0]   srem_d [0:DIV_STEPS];
	logic [CH_W-1:0]    hlow_d [0:DIV_STEPS];
	logic [CH_W-1:0]    slow_d [0:DIV_STEPS];
	logic [DIV_D_W-1:0] hd_d   [0:DIV_STEPS];
	logic [DIV_D_W-1:0] sd_d   [0:DIV_STEPS];
	logic [CH_W-1:0]    hq_d   [0:DIV_STEPS];
	logic [CH_W-1:0]    sq_d   [0:DIV_STEPS];

	sector_t         sec_s3;
	logic [CH_W-1:0] frac_s3, vs_s3, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_d[0] <= 1'b0;
		else
			vld_d[0] <= vld_s2;
	end

	always_ff @(posedge clk) begin
		op_d[0]   <= op_s2;
		zero_d[0] <= (rng_s2 == '0);
		hrem_d[0] <= {1'b0, hnum[26:12]};
		hlow_d[0] <= hnum[11:0];
		hd_d[0]   <= rng6;
		srem_d[0] <= {4'b0, snum[23:12]};
		slow_d[0] <= snum[11:0];
		sd_d[0]   <= {3'b0, mx_s2};
		hq_d[0]   <= '0;
		sq_d[0]   <= '0;
		sec_s3    <= sec_c;
		frac_s3   <= frac_w[CH_W-1:0];
		vs_s3     <= div_scale(vsp_s2);
		// value for hsv, max for rgb; for rgb the max leaves as the third field
		v_s3      <= (op_s2 == OP_HSV2RGB) ? c3_s2 : mx_s2;
	end

	genvar gi;
	generate
		for (gi = 0; gi < DIV_STEPS; gi++) begin : g_div
			div_step_t hst, sst;

			always_comb begin
				hst = div_step(hrem_d[gi], hlow_d[gi][CH_W-1], hd_d[gi]);
				sst = div_step(srem_d[gi], slow_d[gi][CH_W-1], sd_d[gi]);
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_d[gi+1] <= 1'b0;
				else
					vld_d[gi+1] <= vld_d[gi];
			end

			always_ff @(posedge clk) begin
				op_d[gi+1]   <= op_d[gi];
				zero_d[gi+1] <= zero_d[gi];
				hrem_d[gi+1] <= hst.rem;
				srem_d[gi+1] <= sst.rem;
				hlow_d[gi+1] <= hlow_d[gi] << 1;
				slow_d[gi+1] <= slow_d[gi] << 1;
				hd_d[gi+1]   <= hd_d[gi];
				sd_d[gi+1]   <= sd_d[gi];
				hq_d[gi+1]   <= {hq_d[gi][CH_W-2:0], hst.qbit};
				sq_d[gi+1]   <= {sq_d[gi][CH_W-2:0], sst.qbit};
			end
		end
	endgenerate

	// ---- stage 4: p and vs*frac
	sector_t           sec_s4;
	logic [CH_W-1:0]   p_s4, v_s4;
	logic [2*CH_W-1:0] pk_s4;

	always_ff @(posedge clk) begin
		sec_s4 <= sec_s3;
		v_s4   <= v_s3;
		p_s4   <= v_s3 - vs_s3;
		pk_s4  <= {{CH_W{1'b0}}, vs_s3} * {{CH_W{1'b0}}, frac_s3};
	end

	// ---- stage 5: sector select, then side lane to the output
	logic [CH_W-1:0] k_c, up_c, down_c, f1_c, f2_c, f3_c;

	always_comb begin
		k_c    = div_scale(pk_s4);
		up_c   = p_s4 + k_c;
		down_c = v_s4 - k_c;
		case (sec_s4)
			SEC_1: begin
				f1_c = down_c; f2_c = v_s4;   f3_c = p_s4;
			end
			SEC_2: begin
				f1_c = p_s4;   f2_c = v_s4;   f3_c = up_c;
			end
			SEC_3: begin
				f1_c = p_s4;   f2_c = down_c; f3_c = v_s4;
			end
			SEC_4: begin
				f1_c = up_c;   f2_c = p_s4;   f3_c = v_s4;
			end
			SEC_5: begin
				f1_c = v_s4;   f2_c = p_s4;   f3_c = down_c;
			end
			default: begin
				// sector zero and hue of one
				f1_c = v_s4;   f2_c = up_c;   f3_c = p_s4;
			end
		endcase
		if (op_d[1] == OP_RGB2HSV) begin
			f1_c = '0;
			f2_c = '0;
			f3_c = v_s4;
		end
	end

	logic [CH_W-1:0] sf1_d [2:DIV_STEPS];
	logic [CH_W-1:0] sf2_d [2:DIV_STEPS];
	logic [CH_W-1:0] sf3_d [2:DIV_STEPS];

	always_ff @(posedge clk) begin
		sf1_d[2] <= f1_c;
		sf2_d[2] <= f2_c;
		sf3_d[2] <= f3_c;
	end

	generate
		for (gi = 2; gi < DIV_STEPS; gi++) begin : g_side
			always_ff @(posedge clk) begin
				sf1_d[gi+1] <= sf1_d[gi];
				sf2_d[gi+1] <= sf2_d[gi];
				sf3_d[gi+1] <= sf3_d[gi];
			end
		end
	endgenerate

	// ---- stage 16: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vld_d[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		res_third <= sf3_d[DIV_STEPS];
		if (op_d[DIV_STEPS] == OP_HSV2RGB) begin
			res_first  <= sf1_d[DIV_STEPS];
			res_second <= sf2_d[DIV_STEPS];
		end else if (zero_d[DIV_STEPS]) begin
			// gray or black: no hue, no saturation
			res_first  <= '0;
			res_second <= '0;
		end else begin
			res_first  <= hq_d[DIV_STEPS];
			res_second <= sq_d[DIV_STEPS];
		end
	end

endmodule
